>>> rtl/md5_pkg.sv
// Shared types, constants and round tables for the MD5 block compression core.
package md5_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned IdxW       = $clog2(BlockWords);
  localparam int unsigned RoundW     = $clog2(Rounds);
  localparam int unsigned RotW       = $clog2(WordW);

  typedef logic [WordW-1:0]  word_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [RoundW-1:0] round_t;
  typedef logic [RotW-1:0]   rot_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } md5_state_t;

  localparam idx_t   LastWord  = idx_t'(BlockWords - 1);
  localparam round_t LastRound = round_t'(Rounds - 1);

  localparam md5_state_t InitChain = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476
  };

  // Additive constants, one per round, from the integer part of 2^32 * abs(sin(round + 1)).
  function automatic word_t md5_sine(round_t rnd);
    word_t k;
    case (rnd)
      6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB;  6'd63: k = 32'hEB86D391;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Left rotate amount, selected by stage and position in a group of four.
  function automatic rot_t md5_rot(round_t rnd);
    rot_t s;
    case ({rnd[RoundW-1 -: 2], rnd[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = '0;
    endcase
    return s;
  endfunction

  // Message word used by a round; only the low index bits matter, so the
  // products wrap in IdxW bits.
  function automatic idx_t md5_msg_idx(round_t rnd);
    idx_t r;
    idx_t g;
    r = rnd[IdxW-1:0];
    case (rnd[RoundW-1 -: 2])
      2'd0:    g = r;
      2'd1:    g = (r << 2) + r + idx_t'(1);
      2'd2:    g = (r << 1) + r + idx_t'(5);
      2'd3:    g = (r << 3) - r;
      default: g = r;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/md5_round.sv
// One MD5 round: round function, additions, rotate and state shift.
module md5_round (
  input  md5_pkg::md5_state_t st_i,
  input  md5_pkg::word_t      kw_i,
  input  md5_pkg::round_t     round_i,
  output md5_pkg::md5_state_t st_o
);

  md5_pkg::word_t f;
  md5_pkg::word_t sum;
  md5_pkg::rot_t  amt;
  logic [2*md5_pkg::WordW-1:0] rot_wide;
  md5_pkg::word_t rotated;

  always_comb begin
    case (round_i[md5_pkg::RoundW-1 -: 2])
      2'd0:    f = ((st_i.c ^ st_i.d) & st_i.b) ^ st_i.d;
      2'd1:    f = (st_i.d & st_i.b) | (~st_i.d & st_i.c);
      2'd2:    f = st_i.b ^ st_i.c ^ st_i.d;
      2'd3:    f = st_i.c ^ (st_i.b | ~st_i.d);
      default: f = '0;
    endcase
  end

  // The constant and message word arrive already summed in kw_i.
  assign sum      = st_i.a + f + kw_i;
  assign amt      = md5_pkg::md5_rot(round_i);
  assign rot_wide = {sum, sum} << amt;
  assign rotated  = rot_wide[2*md5_pkg::WordW-1 -: md5_pkg::WordW];

  assign st_o.a = st_i.d;
  assign st_o.b = st_i.b + rotated;
  assign st_o.c = st_i.b;
  assign st_o.d = st_i.c;

endmodule

>>> rtl/md5_block_compress_core.sv
// MD5 compression core: buffers sixteen message words and runs 64 rounds per block.
// Each word is accepted in one cycle while the core is loading.
// After the sixteenth word, one round per cycle runs through the shared round
// unit, then a final step adds the working words into the chaining words and
// registers the result; that step waits while an earlier result is not yet taken.
// Reset loads the MD5 initial chaining values and clears the word count.
module md5_block_compress_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  md5_pkg::word_t       msg_word_i,
  input  logic                 new_message_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output md5_pkg::word_t       hash_a_o,
  output md5_pkg::word_t       hash_b_o,
  output md5_pkg::word_t       hash_c_o,
  output md5_pkg::word_t       hash_d_o
);

  typedef enum logic [1:0] {
    StLoad,
    StRound,
    StFinal
  } state_e;

  state_e              state_q, state_d;
  md5_pkg::idx_t       wc_q, wc_d;
  md5_pkg::round_t     round_q, round_d;
  md5_pkg::md5_state_t chain_q, chain_d;
  md5_pkg::md5_state_t work_q, work_d;
  md5_pkg::md5_state_t hash_q, hash_d;
  md5_pkg::word_t      kw_q, kw_d;
  logic                out_valid_q, out_valid_d;
  md5_pkg::word_t      buf_q [md5_pkg::BlockWords];
  logic                buf_we;
  md5_pkg::idx_t       buf_idx;
  md5_pkg::round_t     round_nx;
  md5_pkg::md5_state_t round_st;
  logic                in_acc;

  md5_round u_round (
    .st_i    (work_q),
    .kw_i    (kw_q),
    .round_i (round_q),
    .st_o    (round_st)
  );

  assign in_ready_o = (state_q == StLoad);
  assign in_acc     = in_valid_i && in_ready_o;
  assign round_nx   = round_q + md5_pkg::round_t'(1);

  always_comb begin
    state_d     = state_q;
    wc_d        = wc_q;
    round_d     = round_q;
    chain_d     = chain_q;
    work_d      = work_q;
    kw_d        = kw_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q && !out_ready_i;
    buf_we      = 1'b0;
    buf_idx     = wc_q;
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          buf_we = 1'b1;
          if (new_message_i) begin
            // A flag mid-block drops the partial block and restarts at word zero.
            chain_d = md5_pkg::InitChain;
            buf_idx = '0;
            wc_d    = md5_pkg::idx_t'(1);
          end else if (wc_q == md5_pkg::LastWord) begin
            wc_d    = '0;
            round_d = '0;
            work_d  = chain_q;
            kw_d    = md5_pkg::md5_sine('0) + buf_q[md5_pkg::md5_msg_idx('0)];
            state_d = StRound;
          end else begin
            wc_d = wc_q + md5_pkg::idx_t'(1);
          end
        end
      end
      StRound: begin
        work_d  = round_st;
        // The constant and message word of the next round are summed ahead.
        kw_d    = md5_pkg::md5_sine(round_nx) + buf_q[md5_pkg::md5_msg_idx(round_nx)];
        round_d = round_nx;
        if (round_q == md5_pkg::LastRound) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        if (!out_valid_q || out_ready_i) begin
          chain_d.a   = chain_q.a + work_q.a;
          chain_d.b   = chain_q.b + work_q.b;
          chain_d.c   = chain_q.c + work_q.c;
          chain_d.d   = chain_q.d + work_q.d;
          hash_d      = chain_d;
          out_valid_d = 1'b1;
          state_d     = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      wc_q        <= '0;
      round_q     <= '0;
      chain_q     <= md5_pkg::InitChain;
      hash_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wc_q        <= wc_d;
      round_q     <= round_d;
      chain_q     <= chain_d;
      hash_q      <= hash_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    kw_q   <= kw_d;
    if (buf_we) begin
      buf_q[buf_idx] <= msg_word_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hash_a_o    = hash_q.a;
  assign hash_b_o    = hash_q.b;
  assign hash_c_o    = hash_q.c;
  assign hash_d_o    = hash_q.d;

  a_start_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !new_message_i && wc_q == md5_pkg::LastWord)
      |=> (state_q == StRound && round_q == '0))
    else $error("rounds did not start after the last word of a block");

  a_round_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && round_q != md5_pkg::LastRound)
      |=> (state_q == StRound && round_q == $past(round_nx)))
    else $error("round counter did not advance");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> (wc_q == '0))
    else $error("word count nonzero while compressing");

  a_result_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StFinal && state_q == StLoad))
    else $error("result produced outside the finalization step");

endmodule

>>> dv/tb_md5_block_compress_core.sv
// Self-checking testbench for the MD5 block compression core.
module tb_md5_block_compress_core;

  localparam int unsigned NumItems    = 1400;
  localparam int unsigned IdlePct     = 36;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned MaxReports  = 10;

  localparam md5_pkg::word_t SineTab [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam int unsigned ShiftTab [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  class digest_scoreboard;
    md5_pkg::md5_state_t chain;
    md5_pkg::word_t      blk_words [16];
    int unsigned         fill;
    md5_pkg::md5_state_t digests_due [$];
    int unsigned         mismatches;

    function new();
      chain = md5_pkg::InitChain;
      fill = 0;
      mismatches = 0;
      foreach (blk_words[i]) blk_words[i] = '0;
    endfunction

    function md5_pkg::word_t rotl(md5_pkg::word_t v, int unsigned n);
      return (v << n) | (v >> (md5_pkg::WordW - n));
    endfunction

    function void compress_block();
      md5_pkg::word_t a, b, c, d, f, t;
      int unsigned g, stage;
      a = chain.a;
      b = chain.b;
      c = chain.c;
      d = chain.d;
      for (int unsigned r = 0; r < 64; r++) begin
        stage = r / 16;
        case (stage)
          0: begin f = ((c ^ d) & b) ^ d;   g = r % 16;           end
          1: begin f = (d & b) | (~d & c);  g = (5 * r + 1) % 16; end
          2: begin f = b ^ c ^ d;           g = (3 * r + 5) % 16; end
          default: begin f = c ^ (b | ~d);  g = (7 * r) % 16;     end
        endcase
        t = a + f + SineTab[r] + blk_words[g];
        t = b + rotl(t, ShiftTab[stage * 4 + r % 4]);
        a = d;
        d = c;
        c = b;
        b = t;
      end
      chain.a += a;
      chain.b += b;
      chain.c += c;
      chain.d += d;
    endfunction

    // A flag anywhere drops the partial block and restarts from the initial values.
    function void note_word(md5_pkg::word_t w, logic new_msg);
      if (new_msg) begin
        chain = md5_pkg::InitChain;
        fill = 0;
      end
      blk_words[fill] = w;
      fill++;
      if (fill == md5_pkg::BlockWords) begin
        fill = 0;
        compress_block();
        digests_due.push_back(chain);
      end
    endfunction

    function void check_field(string name, md5_pkg::word_t want, md5_pkg::word_t got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%s mismatch: expected %08h, got %08h", name, want, got);
      end
    endfunction

    function void check_digest(md5_pkg::word_t a, md5_pkg::word_t b,
                               md5_pkg::word_t c, md5_pkg::word_t d);
      md5_pkg::md5_state_t want;
      if (digests_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected digest %08h %08h %08h %08h", a, b, c, d);
        return;
      end
      want = digests_due.pop_front();
      check_field("hash_a", want.a, a);
      check_field("hash_b", want.b, b);
      check_field("hash_c", want.c, c);
      check_field("hash_d", want.d, d);
    endfunction

    function int unsigned pending();
      return digests_due.size();
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  md5_pkg::word_t msg_word_i;
  logic           new_message_i;
  logic           out_valid_o;
  logic           out_ready_i;
  md5_pkg::word_t hash_a_o;
  md5_pkg::word_t hash_b_o;
  md5_pkg::word_t hash_c_o;
  md5_pkg::word_t hash_d_o;

  digest_scoreboard sb;
  int unsigned      words_sent = 0;
  bit               no_idle = 1'b0;
  bit               stall_req = 1'b0;

  md5_block_compress_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .msg_word_i    (msg_word_i),
    .new_message_i (new_message_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hash_a_o      (hash_a_o),
    .hash_b_o      (hash_b_o),
    .hash_c_o      (hash_c_o),
    .hash_d_o      (hash_d_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic md5_pkg::word_t rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input md5_pkg::word_t w, input logic new_msg);
    no_idle = (words_sent >= 500) && (words_sent < 800);
    // Hold the output side off while words keep coming, so the core backs up.
    if (words_sent == 300) stall_req = 1'b1;
    while (!no_idle && ($urandom_range(99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    msg_word_i    <= w;
    new_message_i <= new_msg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(w, new_msg);
    words_sent++;
  endtask

  initial begin : stimulus
    int unsigned len;
    logic        first_flag;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    msg_word_i    <= '0;
    new_message_i <= 1'b0;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First block without any flag hashes from the values reset loaded.
    for (int i = 0; i < 14; i++) send_word((i % 2 == 1) ? 32'hFFFF_FFFF : 32'h0, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    // Flag on a first word, then a partial block that the next flag discards.
    send_word(32'h0000_0080, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b0);

    first_flag = 1'b1;
    while (words_sent < NumItems) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(15, 1) : md5_pkg::BlockWords;
      for (int unsigned i = 0; i < len; i++) send_word(rand_word(), (i == 0) && first_flag);
      first_flag = (len != md5_pkg::BlockWords) || ($urandom_range(2) == 0);
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b1;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_digest(hash_a_o, hash_b_o, hash_c_o, hash_d_o);
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
